// File: rtl/lowest_free_slot_lease_allocator_unit_assert.svh
// Assertion macros used by the allocator top module.
// Each macro expects clk and arst_n in scope.
`ifndef LOWEST_FREE_SLOT_LEASE_ALLOCATOR_UNIT_ASSERT_SVH
`define LOWEST_FREE_SLOT_LEASE_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define LFSL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LFSL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/lfsl_pkg.sv
`default_nettype none
package lfsl_pkg;

	localparam int SLOTS   = 64;
	localparam int IDX_W   = 6;
	localparam int TIME_W  = 32;
	localparam int AMT_W   = 32;
	localparam int LEASE_W = 33;
	localparam int TOTAL_W = 48;
	localparam int ACT_W   = 7;

	localparam logic [ACT_W-1:0]   ACTIVE_RESET = 7'd64;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX    = {TOTAL_W{1'b1}};

	localparam logic FUNC_EVENT = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	// word handed from cell to cell
	typedef struct packed {
		logic               vld;
		logic               hit;
		logic [IDX_W-1:0]   idx;
		logic [TOTAL_W-1:0] total;
	} link_t;

	// current item, broadcast to every cell
	typedef struct packed {
		logic               func;
		logic [AMT_W-1:0]   amount;
		logic [LEASE_W-1:0] lease_new;
		logic [IDX_W-1:0]   rd_slot;
		logic [ACT_W-1:0]   active;
	} item_t;

endpackage
`default_nettype wire

// File: rtl/lfsl_cell.sv
`default_nettype none
module lfsl_cell (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire  [lfsl_pkg::IDX_W-1:0] idx,
	input  wire                        exp_en,
	input  wire  [lfsl_pkg::TIME_W-1:0] exp_time,
	input  wire                        adv,
	input  wire  lfsl_pkg::item_t      item,
	input  wire  lfsl_pkg::link_t      link_in,
	output lfsl_pkg::link_t            link_out
);
	import lfsl_pkg::*;

	logic [LEASE_W-1:0] lease_end_q;
	logic               present_q;
	logic [TOTAL_W-1:0] total_q;
	link_t              link_q;

	logic               expired;
	logic               elig;
	logic               take;
	logic               rd_hit;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] sat;
	link_t              link_nxt;

	assign expired = !present_q && (lease_end_q <= {1'b0, exp_time});
	assign elig    = present_q && ({1'b0, idx} < item.active);
	assign take    = link_in.vld && !link_in.hit && (item.func == FUNC_EVENT) && elig;
	assign rd_hit  = link_in.vld && (item.func == FUNC_READ) && (idx == item.rd_slot);

	assign sum = {1'b0, total_q} + {{(TOTAL_W + 1 - AMT_W){1'b0}}, item.amount};
	assign sat = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

	always_comb begin
		link_nxt = link_in;
		if (take) begin
			link_nxt.hit   = 1'b1;
			link_nxt.idx   = idx;
			link_nxt.total = sat;
		end else if (rd_hit) begin
			link_nxt.idx   = idx;
			link_nxt.total = total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lease_end_q <= '0;
			present_q   <= 1'b1;
			total_q     <= '0;
			link_q      <= '0;
		end else begin
			if (exp_en && expired) begin
				present_q <= 1'b1;
			end
			if (adv) begin
				link_q <= link_nxt;
				if (take) begin
					present_q   <= 1'b0;
					total_q     <= sat;
					lease_end_q <= item.lease_new;
				end
			end
		end
	end

	assign link_out = link_q;

endmodule
`default_nettype wire

// File: rtl/lowest_free_slot_lease_allocator_unit.sv
`default_nettype none
// Lowest-free-slot lease allocator. A pool of 64 slots, each with a lease end,
// a present flag and a saturating 48-bit running total, lives in a row of 64
// cells. A request word (s_tuser = 0) first returns every slot whose lease
// has ended by event_time (all cells compare in parallel on the accept edge),
// then a token walks the row from cell 0 upward, one cell per clock; the
// first present cell below active_slots takes the grant, adds amount to its
// total and stores event_time + lease_length (33 bits) as its new lease end.
// A read word (s_tuser = 1) walks the same row and picks up the total of
// read_slot. Exactly one result word comes out per input word; a request
// with no free slot gives granted = 0, slot_index = 0, slot_total = 0.
// With m_tready held high, each word passes the accept edge, the hops through
// the cell row and the load of the output register before s_tready rises
// again; the token walk through the cell row sets the rate of input words.
// Only one word is in flight; s_tready drops from accept until its result
// reaches the output register, which holds it until taken while the next word
// can already be accepted. A stalled output freezes the row only when the
// token reaches its end. active_slots is to be written by the user through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce
// this. It resets to 64, values above 64 act as 64, zero grants nothing.
module lowest_free_slot_lease_allocator_unit (
	input  wire          clk,
	input  wire          arst_n,
	// configuration: active_slots
	input  wire          cfg_we,
	input  wire  [6:0]   cfg_wdata,
	// input words
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [103:0] s_tdata,  // event_time[31:0], amount[63:32],
	                               // lease_length[95:64], read_slot[101:96], pad
	input  wire          s_tuser,  // func: 0 request, 1 read
	// result words
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [55:0]  m_tdata,  // slot_index[5:0], slot_total[53:6], pad
	output logic         m_tuser   // granted
);
	import lfsl_pkg::*;

	`include "lowest_free_slot_lease_allocator_unit_assert.svh"

	// input field breakout
	logic [TIME_W-1:0] in_time;
	logic [AMT_W-1:0]  in_amount;
	logic [TIME_W-1:0] in_len;
	logic [IDX_W-1:0]  in_slot;

	assign in_time   = s_tdata[31:0];
	assign in_amount = s_tdata[63:32];
	assign in_len    = s_tdata[95:64];
	assign in_slot   = s_tdata[101:96];

	// control and held item
	logic [ACT_W-1:0]   active_q;
	logic               busy_q;
	logic               start_q;
	logic               func_q;
	logic [AMT_W-1:0]   amount_q;
	logic [LEASE_W-1:0] lease_new_q;
	logic [IDX_W-1:0]   rd_slot_q;

	logic  accept;
	logic  exp_en;
	logic  adv;
	logic  tail_load;
	item_t item;
	link_t inject;
	link_t link_w [SLOTS];
	logic [SLOTS-1:0] tok_vec;

	// output register
	logic               out_vld_q;
	logic               out_hit_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic [TOTAL_W-1:0] out_total_q;

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;
	// expiry sweep of every cell happens on the accept edge of a request
	assign exp_en   = accept && (s_tuser == FUNC_EVENT);

	// row moves unless the finished word would land on a full, stalled output
	assign adv       = !link_w[SLOTS-1].vld || !out_vld_q || m_tready;
	assign tail_load = link_w[SLOTS-1].vld && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			start_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tail_load) begin
				busy_q <= 1'b0;
			end
			if (accept) begin
				start_q <= 1'b1;
			end else if (adv) begin
				start_q <= 1'b0;
			end
		end
	end

	// item payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q      <= s_tuser;
			amount_q    <= in_amount;
			lease_new_q <= {1'b0, in_time} + {1'b0, in_len};
			rd_slot_q   <= in_slot;
		end
	end

	always_comb begin
		item.func      = func_q;
		item.amount    = amount_q;
		item.lease_new = lease_new_q;
		item.rd_slot   = rd_slot_q;
		item.active    = active_q;
	end

	// token entering cell 0: nothing found yet, zero fields for the miss case
	always_comb begin
		inject       = '0;
		inject.vld   = start_q;
	end

	// the cell row
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		if (i == 0) begin : g_head
			lfsl_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.idx      (IDX_W'(i)),
				.exp_en   (exp_en),
				.exp_time (in_time),
				.adv      (adv),
				.item     (item),
				.link_in  (inject),
				.link_out (link_w[i])
			);
		end else begin : g_body
			lfsl_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.idx      (IDX_W'(i)),
				.exp_en   (exp_en),
				.exp_time (in_time),
				.adv      (adv),
				.item     (item),
				.link_in  (link_w[i-1]),
				.link_out (link_w[i])
			);
		end
		assign tok_vec[i] = link_w[i].vld;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (tail_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tail_load) begin
			out_hit_q   <= link_w[SLOTS-1].hit;
			out_idx_q   <= link_w[SLOTS-1].idx;
			out_total_q <= link_w[SLOTS-1].total;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_hit_q;
	assign m_tdata  = {2'b00, out_total_q, out_idx_q};

	// checks
	`LFSL_ASSERT_NEXT(a_busy_after_accept, accept, busy_q, "busy not set after accept")
	`LFSL_ASSERT_NOW(a_one_token, 1'b1, $onehot0({tok_vec, start_q}), "more than one token in row")
	`LFSL_ASSERT_NOW(a_idle_no_token, !busy_q, !start_q && (tok_vec == '0), "token while idle")

endmodule
`default_nettype wire
